[hw/rtl/btpc_pkg.sv]
`timescale 1ns / 1ps
package btpc_pkg;
    localparam int RawW  = 19;
    localparam int DataW = 32;
    localparam int CfgW  = 48;
    localparam int IdxW  = 3;

    localparam logic [IdxW-1:0] RegAc1Ac3 = 3'd0;
    localparam logic [IdxW-1:0] RegAc4Ac6 = 3'd1;
    localparam logic [IdxW-1:0] RegB1B2   = 3'd2;
    localparam logic [IdxW-1:0] RegMcMd   = 3'd3;
    localparam logic [IdxW-1:0] RegOss    = 3'd4;

    localparam logic [DataW-1:0] KB6Off  = 32'd4000;
    localparam logic [DataW-1:0] KC3038  = 32'd3038;
    localparam logic [DataW-1:0] KCm7357 = 32'hFFFF_E343;
    localparam logic [DataW-1:0] KC3791  = 32'd3791;
    localparam logic [DataW-1:0] K50000  = 32'd50000;
    localparam logic [DataW-1:0] KSign   = 32'h8000_0000;
    localparam logic [DataW-1:0] K32768  = 32'd32768;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T0, S_T1, S_T2,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_P9, S_P10, S_P11, S_P12, S_P13,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DataW-1:0] num;
        logic [DataW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DataW-1:0] quo;
    } t_div_rsp;

    function automatic logic [DataW-1:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] v,
                                             input logic [4:0] n);
        return DataW'($signed(v) >>> n);
    endfunction
endpackage

[hw/rtl/baro_temp_pressure_compensation_unit.sv]
`timescale 1ns / 1ps
// Accepted items run through the sequencer to o_m_tvalid: a temperature item
// through T0-T2, a pressure item through P0-P13; a zero divisor ends early.
// Each full item makes one pass of the bit-serial divider, from its start request
// to its done state; the other steps share one 32x32 multiplier, at most one per step.
// Throughput: one item in flight; the next item is accepted only once the result
// has been taken. Reset: calibration 0, oversampling 1, B5 0.
module baro_temp_pressure_compensation_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [18:0] raw_value, rest zero
    input  logic [23:0]                  i_s_tdata,
    // [0] mode
    input  logic                         i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [31:0] compensated
    output logic [31:0]                  o_m_tdata,
    // [0] result_kind, [1] divide_fault
    output logic [1:0]                   o_m_tuser,
    input  logic                         i_cfg_we,
    input  logic [btpc_pkg::IdxW-1:0]    i_cfg_idx,
    input  logic [btpc_pkg::CfgW-1:0]    i_cfg_data
);
    localparam int W = btpc_pkg::DataW;

    // calibration registers
    logic [47:0] r_ac13, r_ac46;
    logic [31:0] r_b12, r_mcmd;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac13 <= '0; r_ac46 <= '0; r_b12 <= '0; r_mcmd <= '0;
            r_oss  <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btpc_pkg::RegAc1Ac3: r_ac13 <= i_cfg_data;
                btpc_pkg::RegAc4Ac6: r_ac46 <= i_cfg_data;
                btpc_pkg::RegB1B2:   r_b12  <= i_cfg_data[31:0];
                btpc_pkg::RegMcMd:   r_mcmd <= i_cfg_data[31:0];
                btpc_pkg::RegOss:    r_oss  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    wire [W-1:0] w_ac1 = btpc_pkg::sx16(r_ac13[47:32]);
    wire [W-1:0] w_ac2 = btpc_pkg::sx16(r_ac13[31:16]);
    wire [W-1:0] w_ac3 = btpc_pkg::sx16(r_ac13[15:0]);
    wire [W-1:0] w_ac4 = {16'd0, r_ac46[47:32]};
    wire [W-1:0] w_ac5 = {16'd0, r_ac46[31:16]};
    wire [W-1:0] w_ac6 = {16'd0, r_ac46[15:0]};
    wire [W-1:0] w_b1  = btpc_pkg::sx16(r_b12[31:16]);
    wire [W-1:0] w_b2  = btpc_pkg::sx16(r_b12[15:0]);
    wire [W-1:0] w_mc  = btpc_pkg::sx16(r_mcmd[31:16]);
    wire [W-1:0] w_md  = btpc_pkg::sx16(r_mcmd[15:0]);

    btpc_pkg::t_state r_state, n_state;
    // r_a/r_c hold the running x1/x3/b3/b7 terms, r_b holds b4
    logic [W-1:0] r_raw, r_b5, r_b6, r_sq, r_a, r_b, r_c, r_p, r_out;
    logic         r_mode, r_neg, r_fault;

    btpc_pkg::t_div_req w_req;
    btpc_pkg::t_div_rsp w_rsp;

    btpc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // shared multiplier, operands picked by the sequencer step
    logic [W-1:0] w_ma, w_mb, w_prod;
    assign w_prod = w_ma * w_mb;

    assign o_s_tready = (r_state == btpc_pkg::S_IDLE);
    assign o_m_tvalid = (r_state == btpc_pkg::S_OUT);
    wire w_acc = i_s_tvalid && o_s_tready;

    // temperature: den = x1 + md, numerator mc << 11, signed quotient rebuilt from magnitudes
    wire [W-1:0] w_den_t = r_a + w_md;
    wire [W-1:0] w_mc11  = {w_mc[20:0], 11'd0};
    wire [W-1:0] w_x2    = r_neg ? -w_rsp.quo : w_rsp.quo;
    wire [W-1:0] w_b5    = r_a + w_x2;
    // b3 = trunc(r_c / 4): bias negative values by 3 before the arithmetic shift
    wire [W-1:0] w_b3    = r_c[W-1] ? btpc_pkg::asr(r_c + 32'd3, 5'd2)
                                    : {2'b00, r_c[W-1:2]};
    wire [W-1:0] w_ps    = btpc_pkg::asr(r_p, 5'd8);
    wire [W-1:0] w_k50   = btpc_pkg::K50000 >> r_oss;

    always_comb begin
        n_state = r_state;
        w_req   = '0;
        w_ma    = '0;
        w_mb    = '0;
        case (r_state)
            btpc_pkg::S_IDLE: begin
                if (w_acc) n_state = i_s_tuser ? btpc_pkg::S_P0 : btpc_pkg::S_T0;
            end
            btpc_pkg::S_T0: begin             // (raw - ac6) * ac5
                w_ma    = r_raw - w_ac6;
                w_mb    = w_ac5;
                n_state = btpc_pkg::S_T1;
            end
            btpc_pkg::S_T1: begin             // divisor check, start |mc<<11| / |den|
                if (w_den_t == '0) begin
                    n_state = btpc_pkg::S_OUT;
                end else begin
                    w_req.start = 1'b1;
                    w_req.num   = w_mc11[W-1] ? -w_mc11 : w_mc11;
                    w_req.den   = w_den_t[W-1] ? -w_den_t : w_den_t;
                    n_state     = btpc_pkg::S_T2;
                end
            end
            btpc_pkg::S_T2: begin
                if (w_rsp.done) n_state = btpc_pkg::S_OUT;
            end
            btpc_pkg::S_P0: begin             // b6 * b6
                w_ma    = r_b6;
                w_mb    = r_b6;
                n_state = btpc_pkg::S_P1;
            end
            btpc_pkg::S_P1: begin             // b2 * sq
                w_ma    = w_b2;
                w_mb    = r_sq;
                n_state = btpc_pkg::S_P2;
            end
            btpc_pkg::S_P2: begin             // ac2 * b6
                w_ma    = w_ac2;
                w_mb    = r_b6;
                n_state = btpc_pkg::S_P3;
            end
            btpc_pkg::S_P3: n_state = btpc_pkg::S_P4;
            btpc_pkg::S_P4: begin             // ac3 * b6
                w_ma    = w_ac3;
                w_mb    = r_b6;
                n_state = btpc_pkg::S_P5;
            end
            btpc_pkg::S_P5: begin             // b1 * sq
                w_ma    = w_b1;
                w_mb    = r_sq;
                n_state = btpc_pkg::S_P6;
            end
            btpc_pkg::S_P6: begin             // ac4 * (x3 + 32768)
                w_ma    = w_ac4;
                w_mb    = r_a + btpc_pkg::K32768;
                n_state = btpc_pkg::S_P7;
            end
            btpc_pkg::S_P7: begin             // (raw - b3) * (50000 >> oss)
                w_ma    = r_raw - r_c;
                w_mb    = w_k50;
                n_state = btpc_pkg::S_P8;
            end
            btpc_pkg::S_P8: begin             // b4 check, start b7*2/b4 or b7/b4
                if (r_b == '0) begin
                    n_state = btpc_pkg::S_OUT;
                end else begin
                    w_req.start = 1'b1;
                    w_req.num   = (r_a < btpc_pkg::KSign) ? {r_a[W-2:0], 1'b0} : r_a;
                    w_req.den   = r_b;
                    n_state     = btpc_pkg::S_P9;
                end
            end
            btpc_pkg::S_P9: begin
                if (w_rsp.done) n_state = btpc_pkg::S_P10;
            end
            btpc_pkg::S_P10: begin            // ps * ps
                w_ma    = w_ps;
                w_mb    = w_ps;
                n_state = btpc_pkg::S_P11;
            end
            btpc_pkg::S_P11: begin            // x1 * 3038
                w_ma    = r_a;
                w_mb    = btpc_pkg::KC3038;
                n_state = btpc_pkg::S_P12;
            end
            btpc_pkg::S_P12: begin            // -7357 * p
                w_ma    = btpc_pkg::KCm7357;
                w_mb    = r_p;
                n_state = btpc_pkg::S_P13;
            end
            btpc_pkg::S_P13: n_state = btpc_pkg::S_OUT;
            btpc_pkg::S_OUT: begin
                if (i_m_tready) n_state = btpc_pkg::S_IDLE;
            end
            default: n_state = btpc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btpc_pkg::S_IDLE;
            r_b5    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                btpc_pkg::S_IDLE: begin
                    if (w_acc) begin
                        r_mode  <= i_s_tuser;
                        r_raw   <= W'(i_s_tdata[btpc_pkg::RawW-1:0]);
                        r_fault <= 1'b0;
                        r_out   <= '0;
                        r_b6    <= r_b5 - btpc_pkg::KB6Off;
                    end
                end
                btpc_pkg::S_T0: r_a <= btpc_pkg::asr(w_prod, 5'd15);
                btpc_pkg::S_T1: begin
                    // zero divisor: fault, value 0, B5 kept
                    if (w_den_t == '0) r_fault <= 1'b1;
                    r_neg <= w_mc11[W-1] ^ w_den_t[W-1];
                end
                btpc_pkg::S_T2: begin
                    if (w_rsp.done) begin
                        r_b5  <= w_b5;
                        r_out <= btpc_pkg::asr(w_b5 + 32'd8, 5'd4);
                    end
                end
                btpc_pkg::S_P0: r_sq <= btpc_pkg::asr(w_prod, 5'd12);
                btpc_pkg::S_P1: r_a  <= btpc_pkg::asr(w_prod, 5'd11);
                btpc_pkg::S_P2: r_a  <= r_a + btpc_pkg::asr(w_prod, 5'd11);
                btpc_pkg::S_P3: r_c  <= (({w_ac1[W-3:0], 2'b00} + r_a) << r_oss) + 32'd2;
                btpc_pkg::S_P4: begin
                    r_c <= w_b3;
                    r_a <= btpc_pkg::asr(w_prod, 5'd13);
                end
                btpc_pkg::S_P5: r_a <= btpc_pkg::asr(r_a + btpc_pkg::asr(w_prod, 5'd16) + 32'd2,
                                                     5'd2);
                btpc_pkg::S_P6: r_b <= w_prod >> 15;
                btpc_pkg::S_P7: r_a <= w_prod;
                btpc_pkg::S_P8: begin
                    if (r_b == '0) r_fault <= 1'b1;
                end
                btpc_pkg::S_P9: begin
                    if (w_rsp.done) begin
                        r_p <= (r_a < btpc_pkg::KSign) ? w_rsp.quo
                                                       : {w_rsp.quo[W-2:0], 1'b0};
                    end
                end
                btpc_pkg::S_P10: r_a <= w_prod;
                btpc_pkg::S_P11: r_a <= btpc_pkg::asr(w_prod, 5'd16);
                btpc_pkg::S_P12: r_c <= btpc_pkg::asr(w_prod, 5'd16);
                btpc_pkg::S_P13: r_out <= r_p + btpc_pkg::asr(r_a + r_c + btpc_pkg::KC3791,
                                                              5'd4);
                default: ;
            endcase
        end
    end

    assign o_m_tdata = r_out;
    assign o_m_tuser = {r_fault, r_mode};
endmodule

[hw/rtl/btpc_div.sv]
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module btpc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btpc_pkg::t_div_req  i_req,
    output btpc_pkg::t_div_rsp  o_rsp
);
    localparam int W = btpc_pkg::DataW;

    btpc_pkg::t_div_state r_state, n_state;
    logic [W-1:0]         r_rem, r_quo, r_den;
    logic [4:0]           r_cnt;
    logic [W:0]           w_trial;
    logic [W:0]           w_sh;

    always_comb begin
        w_sh    = {r_rem, r_quo[W-1]};
        w_trial = w_sh - {1'b0, r_den};
        n_state = r_state;
        case (r_state)
            btpc_pkg::DIV_IDLE: if (i_req.start) n_state = btpc_pkg::DIV_RUN;
            btpc_pkg::DIV_RUN:  if (r_cnt == 5'd0) n_state = btpc_pkg::DIV_DONE;
            btpc_pkg::DIV_DONE: n_state = btpc_pkg::DIV_IDLE;
            default:            n_state = btpc_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btpc_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == btpc_pkg::DIV_IDLE && i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_cnt <= 5'd31;
        end else if (r_state == btpc_pkg::DIV_RUN) begin
            r_cnt <= r_cnt - 5'd1;
            if (!w_trial[W]) begin
                r_rem <= w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = (r_state == btpc_pkg::DIV_DONE);
    assign o_rsp.quo  = r_quo;
endmodule
